[hdl/tsq_pkg.sv]
package tsq_pkg;

  localparam int QueueDepthDef = 16;
  localparam int FlowW         = 10;
  localparam int AckW          = 32;
  localparam int TimeW         = 32;
  localparam int CountW        = 5;

  typedef enum logic [1:0] {
    CMD_ENQ  = 2'd0,
    CMD_DEQ  = 2'd1,
    CMD_PEEK = 2'd2
  } cmd_e;

  // One acknowledgement record as held in a cell.
  typedef struct packed {
    logic        [FlowW-1:0] flow_id;
    logic        [AckW-1:0]  cum_ack;
    logic        [AckW-1:0]  sel_ack;
    logic signed [TimeW-1:0] arr_time;
  } rec_t;

  // Operation broadcast to every cell.
  typedef struct packed {
    logic enq;
    logic deq;
  } cell_ctrl_t;

endpackage

[hdl/timestamp_sorted_priority_queue.sv]
// Sorted priority queue of acknowledgement records, ordered by signed receive
// time with the earliest record at the head. Each cell of a row of QueueDepth
// cells compares its own time against the incoming one, and the whole row
// shifts toward the tail on enqueue or toward the head on dequeue, so one
// command transfer is taken every clock while the output is not stalled;
// its result appears in the output register on the next cycle. Records
// with equal times leave in arrival order. An enqueue to a full queue is
// dropped and flagged; dequeue or peek on an empty queue reports out_valid
// low. Every result carries the count, empty and full status after the
// command. Command code 3 only reports status. A new command transfer is
// taken while a result waits, as long as the output side is not stalled.
module timestamp_sorted_priority_queue #(
  parameter int QueueDepth = tsq_pkg::QueueDepthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // command channel
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         cmd_i,
  input  logic [tsq_pkg::FlowW-1:0]          flow_id_i,
  input  logic [tsq_pkg::AckW-1:0]           cum_ack_i,
  input  logic [tsq_pkg::AckW-1:0]           sel_ack_i,
  input  logic signed [tsq_pkg::TimeW-1:0]   arrival_time_i,
  // result channel
  output logic                               res_valid_o,
  input  logic                               res_stall_i,
  output logic                               out_valid_o,
  output logic [tsq_pkg::FlowW-1:0]          out_flow_id_o,
  output logic [tsq_pkg::AckW-1:0]           out_cum_ack_o,
  output logic [tsq_pkg::AckW-1:0]           out_sel_ack_o,
  output logic signed [tsq_pkg::TimeW-1:0]   out_time_o,
  output logic                               dropped_o,
  output logic [tsq_pkg::CountW-1:0]         count_o,
  output logic                               is_empty_o,
  output logic                               is_full_o
);

  localparam int CntW = $clog2(QueueDepth + 1);

  logic                 accept;
  logic                 is_enq, is_deq, is_peek;
  logic                 full, empty;
  logic                 enq_ok, deq_ok, rd_ok;
  logic [CntW-1:0]      count_q, count_d;
  logic [CntW+tsq_pkg::CountW-1:0] count_ext;
  tsq_pkg::cell_ctrl_t  ctrl;
  tsq_pkg::rec_t        new_rec;
  tsq_pkg::rec_t        rec_arr [QueueDepth];
  logic                 gt_arr  [QueueDepth];

  // result register
  logic                 res_valid_q;
  logic                 rd_valid_q;
  tsq_pkg::rec_t        rd_rec_q;
  logic                 dropped_q;
  logic [tsq_pkg::CountW-1:0] res_count_q;
  logic                 empty_q, full_q;

  // a result held under stall blocks the next transfer only while stalled
  assign in_stall_o = res_valid_q && res_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    is_enq  = 1'b0;
    is_deq  = 1'b0;
    is_peek = 1'b0;
    unique case (cmd_i)
      tsq_pkg::CMD_ENQ:  is_enq  = 1'b1;
      tsq_pkg::CMD_DEQ:  is_deq  = 1'b1;
      tsq_pkg::CMD_PEEK: is_peek = 1'b1;
      default: ;  // unused code: status only
    endcase
  end

  assign full   = count_q == CntW'(QueueDepth);
  assign empty  = count_q == '0;
  assign enq_ok = accept && is_enq && !full;
  assign deq_ok = accept && is_deq && !empty;
  assign rd_ok  = accept && (is_deq || is_peek) && !empty;

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + 1'b1;
    end else if (deq_ok) begin
      count_d = count_q - 1'b1;
    end
  end

  assign count_ext = {{tsq_pkg::CountW{1'b0}}, count_d};

  assign ctrl.enq = enq_ok;
  assign ctrl.deq = deq_ok;

  assign new_rec.flow_id  = flow_id_i;
  assign new_rec.cum_ack  = cum_ack_i;
  assign new_rec.sel_ack  = sel_ack_i;
  assign new_rec.arr_time = arrival_time_i;

  // row of cells, head at index 0
  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    tsq_pkg::rec_t left_rec, right_rec;
    logic          left_gt;

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign left_gt  = 1'b0;
    end else begin : g_body
      assign left_rec = rec_arr[i-1];
      assign left_gt  = gt_arr[i-1];
    end

    if (i == QueueDepth - 1) begin : g_tail
      assign right_rec = rec_arr[i];
    end else begin : g_mid
      assign right_rec = rec_arr[i+1];
    end

    tsq_cell #(
      .Idx  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .count_i     (count_q),
      .new_rec_i   (new_rec),
      .left_rec_i  (left_rec),
      .left_gt_i   (left_gt),
      .right_rec_i (right_rec),
      .rec_o       (rec_arr[i]),
      .gt_o        (gt_arr[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (!res_stall_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on each accepted transfer
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_valid_q  <= rd_ok;
      rd_rec_q    <= rd_ok ? rec_arr[0] : '0;
      dropped_q   <= is_enq && full;
      res_count_q <= count_ext[tsq_pkg::CountW-1:0];
      empty_q     <= count_d == '0;
      full_q      <= count_d == CntW'(QueueDepth);
    end
  end

  assign res_valid_o   = res_valid_q;
  assign out_valid_o   = rd_valid_q;
  assign out_flow_id_o = rd_rec_q.flow_id;
  assign out_cum_ack_o = rd_rec_q.cum_ack;
  assign out_sel_ack_o = rd_rec_q.sel_ack;
  assign out_time_o    = rd_rec_q.arr_time;
  assign dropped_o     = dropped_q;
  assign count_o       = res_count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;

  // count never exceeds the row length
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("count above depth");

  // a dropped enqueue is only reported against a full queue
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && dropped_q) |-> full_q)
    else $error("drop reported while not full");

  // no transfer, no change in occupancy
  a_cnt_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(count_q))
    else $error("count moved without a transfer");

  // a dequeue of a non-empty queue removes exactly one record
  a_deq_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_deq && !empty) |=> (count_q == $past(count_q) - 1'b1))
    else $error("dequeue did not remove one record");

endmodule

[hdl/tsq_cell.sv]
module tsq_cell #(
  parameter int Idx  = 0,
  parameter int CntW = 5
) (
  input  logic                  clk_i,
  input  tsq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CntW-1:0]       count_i,
  input  tsq_pkg::rec_t         new_rec_i,
  input  tsq_pkg::rec_t         left_rec_i,
  input  logic                  left_gt_i,
  input  tsq_pkg::rec_t         right_rec_i,
  output tsq_pkg::rec_t         rec_o,
  output logic                  gt_o
);

  tsq_pkg::rec_t rec_q, rec_d;
  logic          occupied;
  logic          at_tail;

  assign occupied = count_i > CntW'(Idx);
  assign at_tail  = count_i == CntW'(Idx);

  // strictly later than the incoming record: the new one goes in front
  assign gt_o = occupied && ($signed(rec_q.arr_time) > $signed(new_rec_i.arr_time));

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.enq) begin
      if (left_gt_i) begin
        rec_d = left_rec_i;          // shift toward tail
      end else if (gt_o || at_tail) begin
        rec_d = new_rec_i;           // insertion point
      end
    end else if (ctrl_i.deq) begin
      rec_d = right_rec_i;           // shift toward head
    end
  end

  always_ff @(posedge clk_i) begin
    rec_q <= rec_d;
  end

  assign rec_o = rec_q;

endmodule
